// ----- rtl/core/c8x_pkg.sv -----
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared constants, opcode groups and types for the CHIP-8 execute core.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [11:0] PC_START = 12'h200;
  localparam logic [15:0] INS_CLS  = 16'h00E0;
  localparam logic [15:0] INS_RET  = 16'h00EE;
  localparam logic [3:0]  VF_IDX   = 4'hF;

  // opcode groups (top nibble)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SEI  = 4'h3;
  localparam logic [3:0] GRP_SNEI = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LDI  = 4'h6;
  localparam logic [3:0] GRP_ADDI = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;

  // 8xyN operations
  localparam logic [3:0] OP_LD   = 4'h0;
  localparam logic [3:0] OP_OR   = 4'h1;
  localparam logic [3:0] OP_AND  = 4'h2;
  localparam logic [3:0] OP_XOR  = 4'h3;
  localparam logic [3:0] OP_ADD  = 4'h4;
  localparam logic [3:0] OP_SUB  = 4'h5;
  localparam logic [3:0] OP_SHR  = 4'h6;
  localparam logic [3:0] OP_SUBN = 4'h7;
  localparam logic [3:0] OP_SHL  = 4'hE;

  typedef struct packed {
    logic       wr_x;   // write result to Vx
    logic [7:0] res;
    logic       wr_f;   // write flag to VF
    logic       flag;
  } alu_t;

endpackage

// ----- rtl/core/c8x_alu.sv -----
// ----------------------------------------------------------------------------
// c8x_alu
// Register write-back logic: 6xkk, 7xkk and the 8xyN group with VF flag.
// ----------------------------------------------------------------------------
module c8x_alu (
  input  logic [3:0]    grp,
  input  logic [3:0]    op,
  input  logic [7:0]    kk,
  input  logic [7:0]    vx,
  input  logic [7:0]    vy,
  output c8x_pkg::alu_t alu
);

  logic [8:0] sum9;

  assign sum9 = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    alu      = '0;
    alu.res  = vx;
    case (grp)
      c8x_pkg::GRP_LDI: begin
        alu.wr_x = 1'b1;
        alu.res  = kk;
      end
      c8x_pkg::GRP_ADDI: begin
        alu.wr_x = 1'b1;
        alu.res  = vx + kk;
      end
      c8x_pkg::GRP_ALU: begin
        case (op)
          c8x_pkg::OP_LD: begin
            alu.wr_x = 1'b1;
            alu.res  = vy;
          end
          c8x_pkg::OP_OR: begin
            alu.wr_x = 1'b1;
            alu.res  = vx | vy;
          end
          c8x_pkg::OP_AND: begin
            alu.wr_x = 1'b1;
            alu.res  = vx & vy;
          end
          c8x_pkg::OP_XOR: begin
            alu.wr_x = 1'b1;
            alu.res  = vx ^ vy;
          end
          c8x_pkg::OP_ADD: begin
            alu.wr_x = 1'b1;
            alu.wr_f = 1'b1;
            alu.res  = sum9[7:0];
            alu.flag = sum9[8];
          end
          c8x_pkg::OP_SUB: begin
            alu.wr_x = 1'b1;
            alu.wr_f = 1'b1;
            alu.res  = vx - vy;
            alu.flag = (vx > vy);
          end
          c8x_pkg::OP_SHR: begin
            alu.wr_x = 1'b1;
            alu.wr_f = 1'b1;
            alu.res  = {1'b0, vx[7:1]};
            alu.flag = vx[0];
          end
          c8x_pkg::OP_SUBN: begin
            alu.wr_x = 1'b1;
            alu.wr_f = 1'b1;
            alu.res  = vy - vx;
            alu.flag = (vy > vx);
          end
          c8x_pkg::OP_SHL: begin
            alu.wr_x = 1'b1;
            alu.wr_f = 1'b1;
            alu.res  = {vx[6:0], 1'b0};
            alu.flag = vx[7];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/chip8_instruction_execute.sv -----
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// CHIP-8 execute core: program counter, V0..VF, return stack, one result
// transaction per instruction.
// ----------------------------------------------------------------------------
// Each instruction transaction on s_* is executed against the current program
// counter, data registers and return stack, and yields one result transaction
// on m_* carrying the next fetch address and the clear-screen, stack-fault and
// not-supported flags. V0..VE and the return stack sit in synchronous RAMs:
// an instruction's register and stack reads are issued when it is accepted,
// and it executes and writes back from the execute stage, which it leaves
// once the output register is free or being taken, with forwarding covering
// a write by the instruction ahead of it. A new instruction can be accepted
// every cycle while the receiver takes results; its result is registered on
// m_* as it leaves the execute stage. The register file reads as zero after
// reset; the return stack needs no clearing since only pushed entries are
// ever popped. No instruction is taken while rst is high.
module chip8_instruction_execute #(
  parameter int unsigned STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] instruction
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [11:0] fetch_address, [12] clear_screen,
                                 // [13] stack_fault, [14] not_supported, [15] 0
);

  localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

  // storage
  logic [7:0]  vreg   [16];
  logic [11:0] rstack [STACK_DEPTH];
  logic [15:0] reg_valid;

  logic [11:0]      pc;
  logic [LVL_W-1:0] lvl;
  logic [7:0]       vf;

  // execute stage
  logic        b_valid;
  logic [15:0] b_ins;
  logic [7:0]  rd_x, rd_y, fwd_data;
  logic        vld_x, vld_y, hit_x, hit_y;
  logic [11:0] stk_rd, stk_fwd;
  logic        stk_hit;

  // output register
  logic        out_valid;
  logic [11:0] out_addr;
  logic        out_cls, out_fault, out_unsup;

  logic in_fire, b_fire;

  logic [3:0]  grp, x, y;
  logic [7:0]  kk, vx, vy, vx_mem, vy_mem;
  logic [11:0] nnn, pc2, pc4, ret_addr, pc_new;
  logic        cls, fault, unsup, push;
  logic [LVL_W-1:0] lvl_new, lvl_eff, lvl_dec;
  logic [IDX_W-1:0] stk_raddr, push_idx;
  logic        mem_we;
  c8x_pkg::alu_t alu;

  assign in_fire  = s_tvalid && s_tready;
  assign b_fire   = b_valid && (!out_valid || m_tready);
  assign s_tready = !rst && (!b_valid || b_fire);

  assign grp = b_ins[15:12];
  assign x   = b_ins[11:8];
  assign y   = b_ins[7:4];
  assign kk  = b_ins[7:0];
  assign nnn = b_ins[11:0];

  assign vx_mem = hit_x ? fwd_data : (vld_x ? rd_x : 8'h00);
  assign vy_mem = hit_y ? fwd_data : (vld_y ? rd_y : 8'h00);
  assign vx     = (x == c8x_pkg::VF_IDX) ? vf : vx_mem;
  assign vy     = (y == c8x_pkg::VF_IDX) ? vf : vy_mem;

  assign pc2      = pc + 12'd2;
  assign pc4      = pc + 12'd4;
  assign ret_addr = stk_hit ? stk_fwd : stk_rd;

  c8x_alu u_alu (
    .grp (grp),
    .op  (b_ins[3:0]),
    .kk  (kk),
    .vx  (vx),
    .vy  (vy),
    .alu (alu)
  );

  always_comb begin
    pc_new  = pc2;
    cls     = 1'b0;
    fault   = 1'b0;
    unsup   = 1'b0;
    push    = 1'b0;
    lvl_new = lvl;
    case (grp)
      c8x_pkg::GRP_SYS: begin
        if (b_ins == c8x_pkg::INS_CLS) begin
          cls = 1'b1;
        end else if (b_ins == c8x_pkg::INS_RET) begin
          if (lvl == '0) begin
            fault = 1'b1;
          end else begin
            lvl_new = lvl - LVL_W'(1);
            pc_new  = ret_addr;
          end
        end else begin
          pc_new = nnn;
        end
      end
      c8x_pkg::GRP_JP: pc_new = nnn;
      c8x_pkg::GRP_CALL: begin
        if (lvl >= LVL_W'(STACK_DEPTH)) begin
          fault = 1'b1;
        end else begin
          push    = 1'b1;
          lvl_new = lvl + LVL_W'(1);
          pc_new  = nnn;
        end
      end
      c8x_pkg::GRP_SEI:  if (vx == kk) pc_new = pc4;
      c8x_pkg::GRP_SNEI: if (vx != kk) pc_new = pc4;
      c8x_pkg::GRP_SER:  if (vx == vy) pc_new = pc4;
      c8x_pkg::GRP_SNER: if (vx != vy) pc_new = pc4;
      c8x_pkg::GRP_LDI, c8x_pkg::GRP_ADDI, c8x_pkg::GRP_ALU: ;
      default: unsup = 1'b1;
    endcase
  end

  // VF lives in a flop; V0..VE in the RAM
  assign mem_we   = b_fire && alu.wr_x && (x != c8x_pkg::VF_IDX);
  assign push_idx = lvl[IDX_W-1:0];

  // stack read for the incoming instruction sees the level after this one
  assign lvl_eff   = b_fire ? lvl_new : lvl;
  assign lvl_dec   = lvl_eff - LVL_W'(1);
  assign stk_raddr = lvl_dec[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vreg[x] <= alu.res;
    end
    if (in_fire) begin
      rd_x <= vreg[s_tdata[11:8]];
      rd_y <= vreg[s_tdata[7:4]];
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && push) begin
      rstack[push_idx] <= pc2;
    end
    if (in_fire) begin
      stk_rd <= rstack[stk_raddr];
    end
  end

  // forwarding info for a write landing on the same edge as the read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_ins    <= s_tdata;
      vld_x    <= reg_valid[s_tdata[11:8]];
      vld_y    <= reg_valid[s_tdata[7:4]];
      hit_x    <= mem_we && (x == s_tdata[11:8]);
      hit_y    <= mem_we && (x == s_tdata[7:4]);
      fwd_data <= alu.res;
      stk_hit  <= b_fire && push && (push_idx == stk_raddr);
      stk_fwd  <= pc2;
    end
    if (b_fire) begin
      out_addr  <= pc_new;
      out_cls   <= cls;
      out_fault <= fault;
      out_unsup <= unsup;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= c8x_pkg::PC_START;
      lvl       <= '0;
      vf        <= 8'h00;
      reg_valid <= '0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (b_fire) begin
        pc  <= pc_new;
        lvl <= lvl_new;
        // result wins over flag when the target is VF
        if (alu.wr_x && (x == c8x_pkg::VF_IDX)) begin
          vf <= alu.res;
        end else if (alu.wr_f) begin
          vf <= {7'b0, alu.flag};
        end
      end
      if (mem_we) begin
        reg_valid[x] <= 1'b1;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_unsup, out_fault, out_cls, out_addr};

endmodule

// ----- rtl/core/c8x_checker.sv -----
// ----------------------------------------------------------------------------
// c8x_checker
// Port-level checks for the CHIP-8 execute core, bound to the top level.
// ----------------------------------------------------------------------------
module c8x_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // no result transaction right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // an instruction raises at most one of the flags, pad bit stays zero
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(m_tdata[14:12]) <= 1) && !m_tdata[15])
    else $error("inconsistent result flags");

  // with the output empty the core always takes an instruction
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // an instruction accepted with the output empty yields a result if not stalled
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid ##1 m_tready |=> m_tvalid)
    else $error("result missing after accepted instruction");

endmodule

bind chip8_instruction_execute c8x_checker u_c8x_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/sv/chip8_instruction_execute_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_execute_tb
// Self-checking bench for the CHIP-8 execute core. A directed table covers
// reset values, every opcode group, each 8xyN operation and the stack limits.
// It is followed by biased random instruction streams with call and return
// storms. Every result transaction is checked against a cycle-free model of
// the counter, V0..VF and the return stack.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_tb;
  import c8x_pkg::*;

  localparam int unsigned STACK_LEVELS = STACK_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DIRECTED_ROWS = 30;

  typedef struct packed {
    logic        pad;
    logic        not_supported;
    logic        stack_fault;
    logic        clear_screen;
    logic [11:0] fetch_address;
  } fetch_result_t;

  typedef struct packed {
    logic [15:0] ins;
    logic [7:0]  reps;
    logic        typed;     // result column is valid
    logic [15:0] result;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] instruction
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [11:0] fetch_address, [12] clear_screen,
                               // [13] stack_fault, [14] not_supported, [15] 0

  // execution model state
  logic [11:0] pc_model;
  logic [7:0]  v_regs [16];
  logic [11:0] ret_stack [STACK_LEVELS];
  int unsigned ret_level;

  fetch_result_t expected_results [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          storm_left = 0;
  logic [3:0]  storm_group = GRP_CALL;
  logic [9:0]  rx_phase = '0;
  stim_row_t   directed [DIRECTED_ROWS];

  chip8_instruction_execute #(
    .STACK_DEPTH(STACK_LEVELS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic void reset_model();
    pc_model = PC_START;
    for (int i = 0; i < 16; i++) v_regs[i] = '0;
    for (int i = 0; i < STACK_LEVELS; i++) ret_stack[i] = '0;
    ret_level = 0;
  endfunction

  function automatic fetch_result_t execute_instruction(input logic [15:0] ins);
    logic [3:0]    grp;
    logic [3:0]    x;
    logic [3:0]    y;
    logic [7:0]    kk;
    logic [7:0]    vx;
    logic [7:0]    vy;
    logic [7:0]    res;
    logic [8:0]    sum;
    logic          flag;
    logic          wr;
    logic [11:0]   nxt;
    fetch_result_t r;
    grp  = ins[15:12];
    x    = ins[11:8];
    y    = ins[7:4];
    kk   = ins[7:0];
    vx   = v_regs[x];
    vy   = v_regs[y];
    res  = '0;
    flag = 1'b0;
    wr   = 1'b0;
    r    = '0;
    nxt  = pc_model + 12'd2;
    case (grp)
      GRP_SYS: begin
        if (ins == INS_CLS) begin
          r.clear_screen = 1'b1;
        end else if (ins == INS_RET) begin
          if (ret_level == 0) begin
            r.stack_fault = 1'b1;
          end else begin
            ret_level--;
            nxt = ret_stack[ret_level];
          end
        end else begin
          nxt = ins[11:0];
        end
      end
      GRP_JP: nxt = ins[11:0];
      GRP_CALL: begin
        if (ret_level >= STACK_LEVELS) begin
          r.stack_fault = 1'b1;
        end else begin
          ret_stack[ret_level] = nxt;
          ret_level++;
          nxt = ins[11:0];
        end
      end
      GRP_SEI:  if (vx == kk) nxt = nxt + 12'd2;
      GRP_SNEI: if (vx != kk) nxt = nxt + 12'd2;
      GRP_SER:  if (vx == vy) nxt = nxt + 12'd2;
      GRP_SNER: if (vx != vy) nxt = nxt + 12'd2;
      GRP_LDI:  v_regs[x] = kk;
      GRP_ADDI: v_regs[x] = vx + kk;
      GRP_ALU: begin
        case (ins[3:0])
          OP_LD:  v_regs[x] = vy;
          OP_OR:  v_regs[x] = vx | vy;
          OP_AND: v_regs[x] = vx & vy;
          OP_XOR: v_regs[x] = vx ^ vy;
          OP_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            res = sum[7:0];
            flag = sum[8];
            wr = 1'b1;
          end
          OP_SUB: begin
            res = vx - vy;
            flag = vx > vy;
            wr = 1'b1;
          end
          OP_SHR: begin
            res = vx >> 1;
            flag = vx[0];
            wr = 1'b1;
          end
          OP_SUBN: begin
            res = vy - vx;
            flag = vy > vx;
            wr = 1'b1;
          end
          OP_SHL: begin
            res = vx << 1;
            flag = vx[7];
            wr = 1'b1;
          end
          default: ;
        endcase
        // flag first so a VF target keeps the result
        if (wr) begin
          v_regs[VF_IDX] = {7'd0, flag};
          v_regs[x] = res;
        end
      end
      default: r.not_supported = 1'b1;
    endcase
    pc_model = nxt;
    r.fetch_address = nxt;
    return r;
  endfunction

  // Biased mix: well-formed skips compare against live register values,
  // and storms drive the return stack into both limits.
  function automatic logic [15:0] pick_instruction();
    int         r;
    logic [3:0] x;
    logic [7:0] kk;
    x  = 4'($urandom_range(0, 15));
    kk = 8'($urandom);
    if ($urandom_range(0, 1) == 0) kk = v_regs[x];
    if (storm_left > 0) begin
      storm_left--;
      if (storm_group == GRP_CALL) return {GRP_CALL, 12'($urandom)};
      return INS_RET;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      storm_left = STACK_LEVELS + 1;
      storm_group = GRP_CALL;
      return {GRP_CALL, 12'($urandom)};
    end
    if (r < 4) begin
      storm_left = STACK_LEVELS + 1;
      storm_group = GRP_SYS;
      return INS_RET;
    end
    if (r < 13) return INS_RET;
    if (r < 16) return INS_CLS;
    if (r < 19) return {GRP_SYS, 12'($urandom)};
    if (r < 23) return {GRP_JP, 12'($urandom)};
    if (r < 31) return {GRP_CALL, 12'($urandom)};
    if (r < 39) return {GRP_SEI, x, kk};
    if (r < 45) return {GRP_SNEI, x, kk};
    if (r < 51) return {GRP_SER, x, 8'($urandom)};
    if (r < 56) return {GRP_SNER, x, 8'($urandom)};
    if (r < 63) return {GRP_LDI, x, 8'($urandom)};
    if (r < 70) return {GRP_ADDI, x, 8'($urandom)};
    if (r < 93) return {GRP_ALU, x, 8'($urandom)};
    return {4'($urandom_range(10, 15)), 12'($urandom)};
  endfunction

  task automatic send_instruction(input logic [15:0] ins, input logic typed,
                                  input logic [15:0] typed_result);
    int            gap;
    fetch_result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= ins;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = execute_instruction(ins);
    if (typed) expected_results.push_back(fetch_result_t'(typed_result));
    else expected_results.push_back(predicted);
  endtask

  // receiver stall pattern, mode taken from the top bits of a free-running phase counter
  always @(posedge clk) begin
    rx_phase <= rx_phase + 10'd1;
    case (rx_phase[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_tready <= (rx_phase[2:0] != 3'd0);
      default: m_tready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    fetch_result_t act;
    fetch_result_t exp;
    if (!rst && m_tvalid && m_tready) begin
      act = fetch_result_t'(m_tdata);
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transaction %h", m_tdata);
      end else begin
        exp = expected_results.pop_front();
        if (act.fetch_address !== exp.fetch_address ||
            act.clear_screen !== exp.clear_screen ||
            act.stack_fault !== exp.stack_fault ||
            act.not_supported !== exp.not_supported) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: addr %h/%h cls %b/%b fault %b/%b unsup %b/%b (exp/act)",
                     exp.fetch_address, act.fetch_address,
                     exp.clear_screen, act.clear_screen,
                     exp.stack_fault, act.stack_fault,
                     exp.not_supported, act.not_supported);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    directed = '{
      // ins, reps, typed, result
      '{16'h00E0, 8'd1, 1'b1, 16'h1202},  // clear screen after reset
      '{16'h00EE, 8'd1, 1'b1, 16'h2204},  // return on empty stack
      '{16'hA123, 8'd1, 1'b1, 16'h4206},
      '{16'hFFFF, 8'd1, 1'b1, 16'h4208},
      '{16'h6FFF, 8'd1, 1'b1, 16'h020A},
      '{16'h60FF, 8'd1, 1'b0, 16'h0000},
      '{16'h7001, 8'd1, 1'b0, 16'h0000},  // add immediate wraps, VF kept
      '{16'h3000, 8'd1, 1'b0, 16'h0000},
      '{16'h4000, 8'd1, 1'b0, 16'h0000},
      '{16'h61AA, 8'd1, 1'b0, 16'h0000},
      '{16'h62FF, 8'd1, 1'b0, 16'h0000},
      '{16'h8124, 8'd1, 1'b0, 16'h0000},  // add with carry out
      '{16'h8125, 8'd1, 1'b0, 16'h0000},
      '{16'h8127, 8'd1, 1'b0, 16'h0000},
      '{16'h8126, 8'd1, 1'b0, 16'h0000},
      '{16'h812E, 8'd1, 1'b0, 16'h0000},
      '{16'h8120, 8'd1, 1'b0, 16'h0000},
      '{16'h8311, 8'd1, 1'b0, 16'h0000},
      '{16'h8312, 8'd1, 1'b0, 16'h0000},
      '{16'h8313, 8'd1, 1'b0, 16'h0000},
      '{16'h8128, 8'd1, 1'b0, 16'h0000},  // unused ALU codes
      '{16'h812F, 8'd1, 1'b0, 16'h0000},
      '{16'h8FF4, 8'd1, 1'b0, 16'h0000},  // VF as target
      '{16'h5121, 8'd1, 1'b0, 16'h0000},  // low nibble ignored
      '{16'h9127, 8'd1, 1'b0, 16'h0000},
      '{16'h0000, 8'd1, 1'b0, 16'h0000},  // system call to 000
      '{16'h1FFE, 8'd1, 1'b0, 16'h0000},
      '{16'h00E0, 8'd1, 1'b0, 16'h0000},  // counter wraps to 000
      '{16'h2300, 8'd17, 1'b0, 16'h0000}, // fill stack, then full fault
      '{16'h00EE, 8'd17, 1'b0, 16'h0000}  // drain stack, then empty fault
    };
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      for (int k = 0; k < directed[i].reps; k++)
        send_instruction(directed[i].ins, directed[i].typed, directed[i].result);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++)
      send_instruction(pick_instruction(), 1'b0, 16'h0000);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
